// File: rtl/braille_cell_text_player_defines.svh
// Assertion macros for the braille cell text player.
`ifndef BRAILLE_CELL_TEXT_PLAYER_DEFINES_SVH
`define BRAILLE_CELL_TEXT_PLAYER_DEFINES_SVH

`ifndef SYNTH
`define BCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/bcp_pkg.sv
// Types, constants and dot table shared by the braille cell text player.
package bcp_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_BYTE   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_BUTTON = 2'd2
    } bcp_mode_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_CLEAR,
        ACT_POP
    } bcp_act_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic       button_level;
    } bcp_in_t;

    typedef struct packed {
        logic [5:0]       cell_dots;
        logic [CNT_W-1:0] fifo_count;
        logic             playing;
        logic             dropped;
    } bcp_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } bcp_fifo_status_t;

    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_EXCL  = 8'h21;

    localparam logic [5:0] LETTER_DOTS [26] = '{
        6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
        6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
        6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
    };

    function automatic logic [5:0] dots_for(input logic [7:0] ch);
        logic [7:0] offs;
        logic [5:0] dots;
        offs = ch - CH_A;
        if (ch >= CH_A && ch <= CH_Z)
        begin
            dots = LETTER_DOTS[offs[4:0]];
        end
        else
        begin
            case (ch)
                CH_SPACE: dots = 6'h3F;
                CH_DOT:   dots = 6'h32;
                CH_COMMA: dots = 6'h02;
                CH_SEMI:  dots = 6'h06;
                CH_APOS:  dots = 6'h04;
                CH_QUEST: dots = 6'h26;
                CH_EXCL:  dots = 6'h16;
                default:  dots = 6'h00;
            endcase
        end
        return dots;
    endfunction

endpackage

// File: rtl/bcp_char_fifo.sv
// Character FIFO: synchronous store with pointers, fill count and registered read.
`include "braille_cell_text_player_defines.svh"

module bcp_char_fifo (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [7:0]                push_data,
    input  logic                      pop,
    output logic [7:0]                rd_data,
    output bcp_pkg::bcp_fifo_status_t status
);
    import bcp_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            count_next  = count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_next  = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign rd_data      = rd_data_reg;
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_FULL);

    `BCP_ASSERT_IMPLY(a_push_pop_excl, clk, rst_n, push, !pop)
    `BCP_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !status.full)
    `BCP_ASSERT_NEXT(a_pop_count, clk, rst_n, pop, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

// File: rtl/braille_cell_text_player.sv
// Braille cell text player top level: control, display stage and output register.
// Accepted items pass through stage 1 (with the FIFO read), then the output register.
// Throughput: one item per cycle unless the output stalls; the character store read
// feeds the two-stage pipeline, and a stalled result holds the display stage behind it.
// Reset (rst_n, async low): FIFO empty, cell blank, playing, active level low,
// last button sample high. The character store is not cleared.
`include "braille_cell_text_player_defines.svh"

module braille_cell_text_player (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  bcp_pkg::bcp_in_t  req_item,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output bcp_pkg::bcp_out_t rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import bcp_pkg::*;

    logic             accept;
    logic             s1_advance;
    logic             push, pop, drop;
    bcp_act_t         act;
    logic [7:0]       rd_data;
    bcp_fifo_status_t fifo_st;
    logic [CNT_W-1:0] count_after;

    logic             active_reg;
    logic             last_btn_reg, last_btn_next;
    logic             play_reg, play_next;
    logic [5:0]       shown_reg, shown_next;

    logic             s1_valid_reg;
    bcp_act_t         s1_act_reg;
    logic [CNT_W-1:0] s1_count_reg;
    logic             s1_play_reg;
    logic             s1_drop_reg;

    logic             out_valid_reg;
    bcp_out_t         out_item_reg;

    bcp_char_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (req_item.byte_value),
        .pop       (pop),
        .rd_data   (rd_data),
        .status    (fifo_st)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || !out_valid_reg || rsp_ready;
    assign accept     = req_valid && req_ready;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        push          = 1'b0;
        pop           = 1'b0;
        drop          = 1'b0;
        act           = ACT_HOLD;
        last_btn_next = last_btn_reg;
        play_next     = play_reg;
        if (accept)
        begin
            case (req_item.mode)
                MODE_BYTE:
                begin
                    if (req_item.byte_value != 8'h00)
                    begin
                        if (fifo_st.full)
                        begin
                            drop = 1'b1;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (play_reg)
                    begin
                        if (fifo_st.empty)
                        begin
                            act = ACT_CLEAR;
                        end
                        else
                        begin
                            pop = 1'b1;
                            act = ACT_POP;
                        end
                    end
                end
                MODE_BUTTON:
                begin
                    last_btn_next = req_item.button_level;
                    if ((req_item.button_level != active_reg) && (last_btn_reg == active_reg))
                    begin
                        play_next = !play_reg;
                        if (play_reg)
                        begin
                            act = ACT_CLEAR;
                        end
                    end
                end
                default:
                begin
                    act = ACT_HOLD;
                end
            endcase
        end
        if (push)
        begin
            count_after = fifo_st.count + CNT_W'(1);
        end
        else if (pop)
        begin
            count_after = fifo_st.count - CNT_W'(1);
        end
        else
        begin
            count_after = fifo_st.count;
        end
    end

    always_comb
    begin
        case (s1_act_reg)
            ACT_POP:   shown_next = dots_for(rd_data);
            ACT_CLEAR: shown_next = '0;
            default:   shown_next = shown_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            last_btn_reg  <= 1'b1;
            play_reg      <= 1'b1;
            shown_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            last_btn_reg <= last_btn_next;
            play_reg     <= play_next;
            if (s1_advance)
            begin
                shown_reg <= shown_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg   <= act;
            s1_count_reg <= count_after;
            s1_play_reg  <= play_next;
            s1_drop_reg  <= drop;
        end
        if (s1_advance)
        begin
            out_item_reg.cell_dots  <= shown_next;
            out_item_reg.fifo_count <= s1_count_reg;
            out_item_reg.playing    <= s1_play_reg;
            out_item_reg.dropped    <= s1_drop_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    `BCP_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && out_valid_reg && !rsp_ready && !accept, s1_valid_reg && $stable(s1_act_reg))
    `BCP_ASSERT_IMPLY(a_drop_full, clk, rst_n, rsp_valid && rsp_item.dropped, rsp_item.fifo_count == CNT_W'(FIFO_DEPTH))
    `BCP_ASSERT_IMPLY(a_pause_blank, clk, rst_n, rsp_valid && !rsp_item.playing, rsp_item.cell_dots == 6'h00)

endmodule

// File: verif/braille_cell_text_player_tb.sv
// Self-checking testbench for the braille cell text player: directed table and random traffic.
module braille_cell_text_player_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcp_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 600;

    localparam logic [5:0] BRAILLE_AZ [26] = '{
        6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
        6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
        6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
    };

    typedef struct {
        bcp_in_t  it;
        int       reps;
        bit       typed;
        bcp_out_t want;
    } stim_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bcp_in_t  req_item = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bcp_out_t rsp_item;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data = 1'b0;

    int send_idle = 10;
    int recv_idle = 77;
    int bad_cells = 0;
    int stall_count = 0;

    bcp_out_t  pending_cells[$];
    stim_row_t directed_rows[$];

    // cell model state
    logic [7:0]       fifo_chars [FIFO_DEPTH];
    logic [PTR_W-1:0] rd_idx = '0;
    logic [PTR_W-1:0] wr_idx = '0;
    logic [CNT_W-1:0] held = '0;
    logic [5:0]       face = '0;
    logic             prev_level = 1'b1;
    logic             is_playing = 1'b1;
    logic             press_level = 1'b0;

    braille_cell_text_player dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [5:0] braille_of(input logic [7:0] ch);
        logic [7:0] offs;
        offs = ch - "a";
        if (ch >= "a" && ch <= "z")
        begin
            return BRAILLE_AZ[offs[4:0]];
        end
        case (ch)
            " ":     return 6'h3F;
            ".":     return 6'h32;
            ",":     return 6'h02;
            ";":     return 6'h06;
            "'":     return 6'h04;
            "?":     return 6'h26;
            "!":     return 6'h16;
            default: return 6'h00;
        endcase
    endfunction

    function automatic bcp_out_t predict_cell(input bcp_in_t it);
        bcp_out_t r;
        logic     rel;
        r.dropped = 1'b0;
        case (it.mode)
            MODE_BYTE:
            begin
                if (it.byte_value != 8'h00)
                begin
                    if (held == FIFO_DEPTH)
                    begin
                        r.dropped = 1'b1;
                    end
                    else
                    begin
                        fifo_chars[wr_idx] = it.byte_value;
                        wr_idx = wr_idx + 1'b1;
                        held = held + 1'b1;
                    end
                end
            end
            MODE_TICK:
            begin
                if (is_playing)
                begin
                    face = 6'h00;
                    if (held != 0)
                    begin
                        face = braille_of(fifo_chars[rd_idx]);
                        rd_idx = rd_idx + 1'b1;
                        held = held - 1'b1;
                    end
                end
            end
            MODE_BUTTON:
            begin
                rel = (it.button_level != press_level) && (prev_level == press_level);
                prev_level = it.button_level;
                if (rel)
                begin
                    if (is_playing)
                    begin
                        is_playing = 1'b0;
                        face = 6'h00;
                    end
                    else
                    begin
                        is_playing = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.cell_dots = face;
        r.fifo_count = held;
        r.playing = is_playing;
        return r;
    endfunction

    function automatic bcp_in_t mk(input logic [1:0] m, input logic [7:0] b, input logic l);
        bcp_in_t it;
        it.mode = m;
        it.byte_value = b;
        it.button_level = l;
        return it;
    endfunction

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 60)
        begin
            return 8'("a" + $urandom_range(25));
        end
        else if (r < 80)
        begin
            case ($urandom_range(7))
                0:       return " ";
                1:       return ".";
                2:       return ",";
                3:       return ";";
                4:       return "'";
                5:       return "?";
                6:       return "!";
                default: return 8'("A" + $urandom_range(25));
            endcase
        end
        else if (r < 95)
        begin
            return 8'($urandom_range(255));
        end
        return 8'h00;
    endfunction

    task automatic send_item(input bcp_in_t it, input bit typed, input bcp_out_t want);
        bcp_out_t got;
        req_valid <= 1'b1;
        req_item <= it;
        do @(posedge clk); while (!req_ready);
        got = predict_cell(it);
        pending_cells.push_back(typed ? want : got);
        if ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic send_rand(input logic [1:0] m, input logic [7:0] b, input logic l);
        send_item(mk(m, b, l), 1'b0, '0);
    endtask

    task automatic add_row(input logic [1:0] m, input logic [7:0] b, input logic l,
                           input int reps, input bit typed, input bcp_out_t want);
        stim_row_t row;
        row.it = mk(m, b, l);
        row.reps = reps;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic program_active_level(input logic lvl);
        req_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= lvl;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        press_level = lvl;
    endtask

    task automatic run_random(input int target);
        int  done;
        int  kind;
        int  len;
        logic [7:0] b;
        done = 0;
        while (done < target)
        begin
            kind = $urandom_range(99);
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 10);
            if (kind < 40)
            begin
                repeat (len)
                begin
                    b = text_byte();
                    send_rand(MODE_BYTE, b, 1'($urandom_range(1)));
                    if (b != 8'h00)
                        done++;
                end
            end
            else if (kind < 75)
            begin
                repeat (len)
                    send_rand(MODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
                done += len;
            end
            else if (kind < 90)
            begin
                // press, then release
                len = $urandom_range(1, 3);
                repeat (len)
                    send_rand(MODE_BUTTON, 8'($urandom_range(255)), press_level);
                done += len;
                len = $urandom_range(1, 2);
                repeat (len)
                    send_rand(MODE_BUTTON, 8'($urandom_range(255)), ~press_level);
                done += len;
            end
            else if (kind < 96)
            begin
                send_rand(MODE_BUTTON, 8'($urandom_range(255)), 1'($urandom_range(1)));
                done++;
            end
            else
            begin
                send_rand(MODE_SPARE, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_cells.size() == 0)
            begin
                $display("%0t: unexpected item: dots=%h count=%0d playing=%b dropped=%b",
                         $time, rsp_item.cell_dots, rsp_item.fifo_count,
                         rsp_item.playing, rsp_item.dropped);
                bad_cells++;
            end
            else if (pending_cells[0].cell_dots != rsp_item.cell_dots
                     || pending_cells[0].fifo_count != rsp_item.fifo_count
                     || pending_cells[0].playing != rsp_item.playing
                     || pending_cells[0].dropped != rsp_item.dropped)
            begin
                $display("%0t: mismatch: expected dots=%h count=%0d playing=%b dropped=%b,",
                         $time, pending_cells[0].cell_dots, pending_cells[0].fifo_count,
                         pending_cells[0].playing, pending_cells[0].dropped,
                         " got dots=%h count=%0d playing=%b dropped=%b",
                         rsp_item.cell_dots, rsp_item.fifo_count,
                         rsp_item.playing, rsp_item.dropped);
                bad_cells++;
                void'(pending_cells.pop_front());
            end
            else
            begin
                void'(pending_cells.pop_front());
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_count <= 0;
        end
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("braille_cell_text_player_tb: done, errors");
            $finish;
        end
        else
        begin
            stall_count <= stall_count + 1;
        end
    end

    initial
    begin
        add_row(MODE_TICK,   8'h00, 1'b0, 1, 1'b1, {6'h00, 7'd0, 1'b1, 1'b0});
        add_row(MODE_BYTE,   8'h00, 1'b0, 1, 1'b1, {6'h00, 7'd0, 1'b1, 1'b0});
        add_row(MODE_SPARE,  8'hFF, 1'b1, 1, 1'b1, {6'h00, 7'd0, 1'b1, 1'b0});
        add_row(MODE_BYTE,   "e",   1'b1, 1, 1'b1, {6'h00, 7'd1, 1'b1, 1'b0});
        add_row(MODE_BYTE,   "z",   1'b0, 1, 1'b1, {6'h00, 7'd2, 1'b1, 1'b0});
        add_row(MODE_BYTE,   " ",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   ".",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   ",",   1'b1, 1, 1'b0, '0);
        add_row(MODE_BYTE,   ";",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   "'",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   "?",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   "!",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   "A",   1'b0, 1, 1'b0, '0);
        add_row(MODE_BYTE,   8'hFF, 1'b0, 1, 1'b0, '0);
        add_row(MODE_TICK,   8'h00, 1'b0, 11, 1'b0, '0);
        add_row(MODE_BUTTON, 8'h00, 1'b0, 1, 1'b0, '0);
        add_row(MODE_BUTTON, 8'h00, 1'b1, 1, 1'b1, {6'h00, 7'd0, 1'b0, 1'b0});
        add_row(MODE_BYTE,   "b",   1'b0, 1, 1'b1, {6'h00, 7'd1, 1'b0, 1'b0});
        add_row(MODE_TICK,   8'h00, 1'b0, 1, 1'b1, {6'h00, 7'd1, 1'b0, 1'b0});
        add_row(MODE_BUTTON, 8'h00, 1'b0, 1, 1'b1, {6'h00, 7'd1, 1'b0, 1'b0});
        add_row(MODE_BUTTON, 8'hFF, 1'b1, 1, 1'b1, {6'h00, 7'd1, 1'b1, 1'b0});
        add_row(MODE_TICK,   8'h00, 1'b0, 1, 1'b1, {6'h03, 7'd0, 1'b1, 1'b0});
        add_row(MODE_TICK,   8'h00, 1'b0, 1, 1'b1, {6'h00, 7'd0, 1'b1, 1'b0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 10;
        recv_idle = 77;
        program_active_level(1'b0);
        foreach (directed_rows[i])
        begin
            repeat (directed_rows[i].reps)
                send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        end

        program_active_level(1'b1);
        run_random(PHASE_ITEMS);

        send_idle = 77;
        recv_idle = 10;
        program_active_level(1'b0);
        run_random(PHASE_ITEMS);

        send_idle = 0;
        recv_idle = 0;
        program_active_level(1'b1);
        run_random(PHASE_ITEMS);

        req_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (bad_cells == 0)
            $display("braille_cell_text_player_tb: done, clean");
        else
            $display("braille_cell_text_player_tb: done, errors");
        $finish;
    end

endmodule
